// ===== src/fsd_pkg.sv =====
`default_nettype none

package fsd_pkg;

    localparam int PIX_W       = 8;
    localparam int LW_W        = 11;
    localparam int LW_RESET    = 256;
    localparam int PIX_HALF    = 128;
    localparam int PIX_FULL    = 255;
    localparam int SHARE_SHIFT = 4;
    localparam int ERR_HEAD    = 10;

    localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(PIX_FULL);
    localparam logic [PIX_W-1:0] PIX_BLACK = '0;

endpackage

`default_nettype wire

// ===== src/fsd_line_mem.sv =====
`default_nettype none

module fsd_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    output logic               clr_busy
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          we;
    logic [AW-1:0] wa;
    logic [DW-1:0] wd;

    // clearing sweep after reset owns the write port
    always_comb begin
        if (clr_busy_reg) begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end else begin
            we = wr_en;
            wa = wr_addr;
            wd = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // same-cycle write bypass on both read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= (we && wa == rd_addr_a) ? wd : mem[rd_addr_a];
            rd_b_reg <= (we && wa == rd_addr_b) ? wd : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign clr_busy  = clr_busy_reg;

endmodule

`default_nettype wire

// ===== src/floyd_steinberg_dither_top.sv =====
// an input beat passes through the pixel register, then the result register
// throughput: one pixel per clock unless stalled, bound by the line store write port
// the line store takes one read at two addresses and at most one write per pixel
// reset: synchronous active-low; afterwards the line store is swept to zero,
// one entry per cycle through all MAX_WIDTH entries, with s_tready held low
`default_nettype none

module floyd_steinberg_dither_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [fsd_pkg::LW_W-1:0]  cfg_wr_data,  // line_width
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [fsd_pkg::PIX_W-1:0] s_tdata,      // pixel_in
    input  wire logic                      s_tuser,      // frame_start
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [fsd_pkg::PIX_W-1:0] m_tdata,      // pixel_out
    output logic                           m_tlast       // row_end
);

    import fsd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > LW_W) ? AW + 1 : LW_W;
    localparam int EW = FRAC_BITS + ERR_HEAD;
    localparam int PW = EW + 3;
    localparam logic signed [EW-1:0] THR_FIX  = EW'(PIX_HALF * (2 ** FRAC_BITS));
    localparam logic signed [EW-1:0] FULL_FIX = EW'(PIX_FULL * (2 ** FRAC_BITS));

    logic [LW_W-1:0]        lw_reg;
    logic [AW-1:0]          cnt_reg;
    logic                   st1_valid_reg;
    logic [PIX_W-1:0]       st1_pix_reg;
    logic                   st1_fs_reg;
    logic [AW-1:0]          st1_col_reg;
    logic                   st1_last_reg;
    logic signed [EW-1:0]   rc_reg;
    logic signed [EW-1:0]   brc_reg;
    logic                   first_row_reg;
    logic                   p_valid_reg;
    logic [AW-1:0]          p_addr_reg;
    logic signed [EW-1:0]   p_data_reg;
    logic                   m_valid_reg;
    logic [PIX_W-1:0]       m_data_reg;
    logic                   m_last_reg;

    logic                   clr_busy;
    logic                   s_accept;
    logic                   st1_adv;
    logic [WW-1:0]          lw_x;
    logic [WW-1:0]          w_eff;
    logic [WW-1:0]          last_col;
    logic [WW-1:0]          cnt_x;
    logic [WW-1:0]          col_x;
    logic [AW-1:0]          acc_col;
    logic                   acc_last;
    logic [AW-1:0]          cnt_next;
    logic [AW-1:0]          rd_prev_addr;
    logic [EW-1:0]          rd_cur;
    logic [EW-1:0]          rd_prev;

    logic                   first_eff;
    logic signed [EW-1:0]   rc_eff;
    logic signed [EW-1:0]   brc_eff;
    logic signed [EW-1:0]   cur_err;
    logic signed [EW-1:0]   prev_err;
    logic signed [EW-1:0]   pix_fix;
    logic signed [EW-1:0]   v;
    logic                   bright;
    logic signed [EW-1:0]   e;
    logic signed [PW-1:0]   e_x;
    logic signed [PW-1:0]   p7;
    logic signed [PW-1:0]   p3;
    logic signed [PW-1:0]   p5;
    logic signed [PW-1:0]   p1;
    logic signed [PW-1:0]   q7;
    logic signed [PW-1:0]   q3;
    logic signed [PW-1:0]   q5;
    logic signed [PW-1:0]   q1;
    logic signed [EW-1:0]   sh7;
    logic signed [EW-1:0]   sh3;
    logic signed [EW-1:0]   sh5;
    logic signed [EW-1:0]   sh1;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    assign st1_adv  = st1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_busy && (!st1_valid_reg || st1_adv);
    assign s_accept = s_tvalid && s_tready;

    // column of the incoming pixel, from width and frame start
    always_comb begin
        lw_x = WW'(lw_reg);
        if (lw_reg == '0) begin
            w_eff = WW'(1);
        end else if (lw_x > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = lw_x;
        end
        last_col     = w_eff - 1'b1;
        cnt_x        = s_tuser ? '0 : WW'(cnt_reg);
        col_x        = (cnt_x >= w_eff) ? last_col : cnt_x;
        acc_col      = col_x[AW-1:0];
        acc_last     = (col_x == last_col);
        cnt_next     = acc_last ? '0 : acc_col + 1'b1;
        rd_prev_addr = acc_col - 1'b1;
    end

    fsd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (EW)
    ) u_line_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (acc_col),
        .rd_addr_b (rd_prev_addr),
        .rd_data_a (rd_cur),
        .rd_data_b (rd_prev),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .clr_busy  (clr_busy)
    );

    // quantize and split the error
    always_comb begin
        first_eff = st1_fs_reg || first_row_reg;
        rc_eff    = st1_fs_reg ? '0 : rc_reg;
        brc_eff   = st1_fs_reg ? '0 : brc_reg;
        if (first_eff) begin
            cur_err = '0;
        end else if (p_valid_reg && p_addr_reg == st1_col_reg) begin
            cur_err = p_data_reg;
        end else begin
            cur_err = $signed(rd_cur);
        end
        prev_err = p_valid_reg ? p_data_reg : $signed(rd_prev);
        pix_fix  = $signed({{(EW - PIX_W - FRAC_BITS){1'b0}}, st1_pix_reg,
                            {FRAC_BITS{1'b0}}});
        v        = pix_fix + rc_eff + cur_err;
        bright   = (v >= THR_FIX);
        e        = bright ? v - FULL_FIX : v;
        e_x      = PW'(e);
        p7       = (e_x <<< 3) - e_x;
        p3       = (e_x <<< 1) + e_x;
        p5       = (e_x <<< 2) + e_x;
        p1       = e_x;
        q7       = p7 >>> SHARE_SHIFT;
        q3       = p3 >>> SHARE_SHIFT;
        q5       = p5 >>> SHARE_SHIFT;
        q1       = p1 >>> SHARE_SHIFT;
        sh7      = q7[EW-1:0];
        sh3      = q3[EW-1:0];
        sh5      = q5[EW-1:0];
        sh1      = q1[EW-1:0];
    end

    // retire the pending entry: add the below-left share or flush as is
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = p_addr_reg;
        wr_data = p_data_reg;
        if (st1_adv) begin
            if (st1_col_reg != '0) begin
                wr_en   = 1'b1;
                wr_addr = st1_col_reg - 1'b1;
                wr_data = prev_err + sh3;
            end else begin
                wr_en   = p_valid_reg;
            end
        end else if (cfg_wr_en && p_valid_reg) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= LW_W'(LW_RESET);
        end else if (cfg_wr_en) begin
            lw_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                cnt_reg       <= cnt_next;
                st1_valid_reg <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_pix_reg  <= s_tdata;
            st1_fs_reg   <= s_tuser;
            st1_col_reg  <= acc_col;
            st1_last_reg <= acc_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg        <= '0;
            brc_reg       <= '0;
            first_row_reg <= 1'b1;
            p_valid_reg   <= 1'b0;
        end else if (st1_adv) begin
            rc_reg        <= st1_last_reg ? '0 : sh7;
            brc_reg       <= st1_last_reg ? '0 : sh1;
            first_row_reg <= st1_last_reg ? 1'b0 : first_eff;
            p_valid_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            p_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            p_addr_reg <= st1_col_reg;
            p_data_reg <= sh5 + brc_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_data_reg <= bright ? PIX_WHITE : PIX_BLACK;
            m_last_reg <= st1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("input taken during line store clear");

    a_binary_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == PIX_WHITE || m_tdata == PIX_BLACK))
        else $error("output pixel not black or white");

    a_stage_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !m_valid_reg |=> m_valid_reg)
        else $error("pixel stage did not reach output register");

    a_pending_after_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_adv |=> p_valid_reg && p_addr_reg == $past(st1_col_reg))
        else $error("pending line store entry not captured");
`endif

endmodule

`default_nettype wire
